// ===== hw/rtl/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg - shared types and constants of the console line editor
// Byte codes, line status codes, controller states and the command and
// status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package cle_pkg;

   // default depth of the line store
   localparam int LINE_BYTES_DEFAULT = 32;

   // reset value of the line limit register
   localparam logic [4:0] MAX_LINE_RESET = 5'd31;

   // key and echo byte codes
   localparam logic [7:0] KEY_BS     = 8'h08;
   localparam logic [7:0] KEY_DEL    = 8'h7F;
   localparam logic [7:0] KEY_CR     = 8'h0D;
   localparam logic [7:0] KEY_CANCEL = 8'h03;
   localparam logic [7:0] KEY_ESC    = 8'h1B;
   localparam logic [7:0] CHR_BEL    = 8'h07;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_CARET  = 8'h5E;
   localparam logic [7:0] CHR_C      = 8'h43;

   // line status codes
   localparam logic [1:0] LINE_EDIT   = 2'd0;
   localparam logic [1:0] LINE_DONE   = 2'd1;
   localparam logic [1:0] LINE_CANCEL = 2'd2;

   // class of a received byte
   typedef enum logic [2:0] {
      KIND_CR,
      KIND_CANCEL,
      KIND_ERASE,
      KIND_ESC,
      KIND_PLAIN
   } kind_type;

   // which byte an echo beat carries
   typedef enum logic [2:0] {
      ECHO_RX,
      ECHO_CR,
      ECHO_LF,
      ECHO_BS,
      ECHO_SPACE,
      ECHO_CARET,
      ECHO_C,
      ECHO_BEL
   } echo_sel_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ECHO,
      ST_READ,
      ST_DRAIN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic         latch;        // take the accepted byte
      logic         emit;         // load an echo beat into the output
      echo_sel_type echo_sel;
      logic [1:0]   echo_status;
      logic         echo_last;
      logic         store;        // write byte at position, advance
      logic         pos_dec;      // step position back
      logic         pos_clear;    // empty the line
      logic         rd_start;     // read first line byte
      logic         drain_load;   // load a line byte into the output
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     pos_zero;
      logic     line_full;
      logic     out_free;
      logic     drain_end;
   } stat_type;

endpackage

// ===== hw/rtl/console_line_editor.sv =====
// ----------------------------------------------------------------------------
// console_line_editor - canonical line input for a serial console
// Edits a console line, echoes each key and hands completed lines on.
// ----------------------------------------------------------------------------
// One received byte is taken at a time. A byte whose edit has been applied
// frees the input again. Carriage return on a line that is not empty then
// reads the line out through the single registered port of the line store,
// one byte a cycle while the result side does not stall. Each echo or line
// byte is one result beat. The line holds at most the smaller of
// max_line_length and LINE_BYTES - 1 bytes; the store needs no clearing
// after reset, so the block takes bytes from the first cycle out of reset.
// ----------------------------------------------------------------------------
module console_line_editor #(
   parameter int LINE_BYTES = cle_pkg::LINE_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_to_terminal,
   output logic [1:0] rsp_line_status,
   output logic [4:0] rsp_line_length,
   output logic       rsp_last
);

   cle_pkg::cmd_type  cmd;
   cle_pkg::stat_type stat;

   // sequencer
   cle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store, position and output beat
   cle_datapath #(
      .LINE_BYTES (LINE_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_rx_byte     (req_rx_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_to_terminal (rsp_to_terminal),
      .rsp_line_status (rsp_line_status),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

// ===== hw/rtl/cle_ctrl.sv =====
// ----------------------------------------------------------------------------
// cle_ctrl - sequencer of the console line editor
// Walks the echo sequence of each byte, applies the edit at its end and
// runs the drain of a completed line.
// ----------------------------------------------------------------------------
module cle_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cle_pkg::stat_type stat,
   output cle_pkg::cmd_type  cmd
);

   cle_pkg::state_type state_ff, state_in;
   logic [1:0]         step_ff, step_in;

   // echo table lookup
   cle_pkg::echo_sel_type sel;
   logic [1:0]            status;
   logic                  last;
   logic                  fin;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cle_pkg::ST_IDLE;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // pick the echo beat for this step
   always_comb begin
      sel    = cle_pkg::ECHO_BEL;
      status = cle_pkg::LINE_EDIT;
      last   = 1'b0;
      fin    = 1'b0;
      unique case (stat.kind)
         cle_pkg::KIND_CR: begin
            if (step_ff == 2'd0) begin
               sel = cle_pkg::ECHO_CR;
            end else begin
               sel = cle_pkg::ECHO_LF;
               fin = 1'b1;
               if (stat.pos_zero) begin
                  last   = 1'b1;
                  status = cle_pkg::LINE_DONE;
               end
            end
         end
         cle_pkg::KIND_CANCEL: begin
            unique case (step_ff)
               2'd0: sel = cle_pkg::ECHO_CARET;
               2'd1: sel = cle_pkg::ECHO_C;
               2'd2: sel = cle_pkg::ECHO_CR;
               default: begin
                  sel    = cle_pkg::ECHO_LF;
                  fin    = 1'b1;
                  last   = 1'b1;
                  status = cle_pkg::LINE_CANCEL;
               end
            endcase
         end
         cle_pkg::KIND_ERASE: begin
            if (stat.pos_zero) begin
               sel  = cle_pkg::ECHO_BEL;
               fin  = 1'b1;
               last = 1'b1;
            end else if (step_ff == 2'd1) begin
               sel = cle_pkg::ECHO_SPACE;
            end else begin
               sel = cle_pkg::ECHO_BS;
               if (step_ff == 2'd2) begin
                  fin  = 1'b1;
                  last = 1'b1;
               end
            end
         end
         cle_pkg::KIND_PLAIN: begin
            sel  = stat.line_full ? cle_pkg::ECHO_BEL : cle_pkg::ECHO_RX;
            fin  = 1'b1;
            last = 1'b1;
         end
         default: begin
            fin = 1'b1;
         end
      endcase
   end

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      req_ready       = 1'b0;
      cmd             = '0;
      cmd.echo_sel    = sel;
      cmd.echo_status = status;
      cmd.echo_last   = last;
      unique case (state_ff)
         cle_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = cle_pkg::ST_DECODE;
            end
         end
         cle_pkg::ST_DECODE: begin
            step_in  = 2'd0;
            state_in = (stat.kind == cle_pkg::KIND_ESC) ? cle_pkg::ST_IDLE
                                                        : cle_pkg::ST_ECHO;
         end
         cle_pkg::ST_ECHO: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (fin) begin
                  step_in  = 2'd0;
                  state_in = cle_pkg::ST_IDLE;
                  // apply the edit once the echo is out
                  unique case (stat.kind)
                     cle_pkg::KIND_PLAIN:  cmd.store   = !stat.line_full;
                     cle_pkg::KIND_ERASE:  cmd.pos_dec = !stat.pos_zero;
                     cle_pkg::KIND_CANCEL: cmd.pos_clear = 1'b1;
                     cle_pkg::KIND_CR: begin
                        if (!stat.pos_zero) begin
                           state_in = cle_pkg::ST_READ;
                        end
                     end
                     default: ;
                  endcase
               end else begin
                  step_in = step_ff + 2'd1;
               end
            end
         end
         cle_pkg::ST_READ: begin
            cmd.rd_start = 1'b1;
            state_in     = cle_pkg::ST_DRAIN;
         end
         cle_pkg::ST_DRAIN: begin
            if (stat.out_free) begin
               cmd.drain_load = 1'b1;
               if (stat.drain_end) begin
                  cmd.pos_clear = 1'b1;
                  state_in      = cle_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = cle_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== hw/rtl/cle_datapath.sv =====
// ----------------------------------------------------------------------------
// cle_datapath - line store, fill position and output register
// Holds the received byte, the edited line and the limit register, and
// forms every result beat under command of the controller.
// ----------------------------------------------------------------------------
module cle_datapath #(
   parameter int LINE_BYTES = cle_pkg::LINE_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        req_rx_byte,
   input  logic              csr_wr_en,
   input  logic [4:0]        csr_wr_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_to_terminal,
   output logic [1:0]        rsp_line_status,
   output logic [4:0]        rsp_line_length,
   output logic              rsp_last,
   input  cle_pkg::cmd_type  cmd,
   output cle_pkg::stat_type stat
);

   localparam int         AW    = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
   localparam logic [8:0] LIMIT = 9'(LINE_BYTES - 1);

   logic [7:0] mem [LINE_BYTES];

   logic [7:0] rx_ff;
   logic [4:0] max_ff;
   logic [4:0] pos_ff, pos_in;
   logic [4:0] cnt_ff;
   logic [7:0] rd_ff;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       term_ff;
   logic [1:0] status_ff;
   logic [4:0] len_ff;
   logic       last_ff;

   logic [5:0] cnt_next;
   logic [7:0] echo_byte;
   logic       rd_en;
   logic [AW-1:0] rd_addr;
   cle_pkg::kind_type kind;

   assign cnt_next = 6'(cnt_ff) + 6'd1;

   // classify the held byte
   always_comb begin
      priority if (rx_ff == cle_pkg::KEY_CR) begin
         kind = cle_pkg::KIND_CR;
      end else if (rx_ff == cle_pkg::KEY_CANCEL) begin
         kind = cle_pkg::KIND_CANCEL;
      end else if (rx_ff == cle_pkg::KEY_BS || rx_ff == cle_pkg::KEY_DEL) begin
         kind = cle_pkg::KIND_ERASE;
      end else if (rx_ff == cle_pkg::KEY_ESC) begin
         kind = cle_pkg::KIND_ESC;
      end else begin
         kind = cle_pkg::KIND_PLAIN;
      end
   end

   assign stat.kind      = kind;
   assign stat.pos_zero  = (pos_ff == 5'd0);
   assign stat.line_full = (pos_ff >= max_ff) || (9'(pos_ff) >= LIMIT);
   assign stat.out_free  = !valid_ff || rsp_ready;
   assign stat.drain_end = (cnt_next == 6'(pos_ff));

   // echo byte for the selected code
   always_comb begin
      unique case (cmd.echo_sel)
         cle_pkg::ECHO_RX:    echo_byte = rx_ff;
         cle_pkg::ECHO_CR:    echo_byte = cle_pkg::KEY_CR;
         cle_pkg::ECHO_LF:    echo_byte = cle_pkg::CHR_LF;
         cle_pkg::ECHO_BS:    echo_byte = cle_pkg::KEY_BS;
         cle_pkg::ECHO_SPACE: echo_byte = cle_pkg::CHR_SPACE;
         cle_pkg::ECHO_CARET: echo_byte = cle_pkg::CHR_CARET;
         cle_pkg::ECHO_C:     echo_byte = cle_pkg::CHR_C;
         default:             echo_byte = cle_pkg::CHR_BEL;
      endcase
   end

   // hold received byte
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         rx_ff <= req_rx_byte;
      end
   end

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= cle_pkg::MAX_LINE_RESET;
      end else if (csr_wr_en) begin
         max_ff <= csr_wr_data;
      end
   end

   // fill position
   always_comb begin
      priority if (cmd.pos_clear) begin
         pos_in = 5'd0;
      end else if (cmd.pos_dec) begin
         pos_in = pos_ff - 5'd1;
      end else if (cmd.store) begin
         pos_in = pos_ff + 5'd1;
      end else begin
         pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 5'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // line store: write at the position, read the next drain byte ahead
   assign rd_en   = cmd.rd_start || cmd.drain_load;
   assign rd_addr = cmd.rd_start ? '0 : AW'(cnt_next);

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[AW'(pos_ff)] <= rx_ff;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // drain index of the byte in the read register
   always_ff @(posedge clock) begin
      if (cmd.rd_start) begin
         cnt_ff <= 5'd0;
      end else if (cmd.drain_load) begin
         cnt_ff <= cnt_next[4:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.drain_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         byte_ff   <= echo_byte;
         term_ff   <= 1'b1;
         status_ff <= cmd.echo_status;
         len_ff    <= 5'd0;
         last_ff   <= cmd.echo_last;
      end else if (cmd.drain_load) begin
         byte_ff   <= rd_ff;
         term_ff   <= 1'b0;
         status_ff <= stat.drain_end ? cle_pkg::LINE_DONE : cle_pkg::LINE_EDIT;
         len_ff    <= stat.drain_end ? pos_ff : 5'd0;
         last_ff   <= stat.drain_end;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_to_terminal = term_ff;
   assign rsp_line_status = status_ff;
   assign rsp_line_length = len_ff;
   assign rsp_last        = last_ff;

endmodule

// ===== hw/rtl/cle_checker.sv =====
// ----------------------------------------------------------------------------
// cle_checker - port-level checks of the console line editor
// Watches the top level's ports and flags beats that break the line rules.
// ----------------------------------------------------------------------------
module cle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_to_terminal,
   input logic [1:0] rsp_line_status,
   input logic [4:0] rsp_line_length,
   input logic       rsp_last
);

   // a line ending is reported only on the final beat of a byte
   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_status != cle_pkg::LINE_EDIT) |-> rsp_last)
      else $error("line status on a beat that is not last");

   // a length comes only with a completed line on a line byte
   a_length_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_length != 5'd0) |->
      (rsp_line_status == cle_pkg::LINE_DONE && !rsp_to_terminal && rsp_last))
      else $error("line length outside a completed line");

   // one byte at a time: the input closes after each accepted beat
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input open directly after an accepted beat");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last)))
      else $error("stalled result beat changed");

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);
